// ----- hw/rtl/csrvi_pkg.sv -----
// ----------------------------------------------------------------------------
// csrvi_pkg
// Shared types, sizes and arithmetic helpers of the value-indexed CSR
// sparse matrix-vector multiply unit.
// ----------------------------------------------------------------------------
package csrvi_pkg;

  localparam int VALUE_SLOTS    = 256;
  localparam int VECTOR_DEPTH   = 4096;
  localparam int ROW_COUNT_BITS = 16;

  localparam int SLOT_W = $clog2(VALUE_SLOTS);
  localparam int COL_W  = $clog2(VECTOR_DEPTH);

  localparam int OUT_FIFO_DEPTH = 8;
  localparam int FIFO_PTR_W     = $clog2(OUT_FIFO_DEPTH);
  localparam int FIFO_CNT_W     = FIFO_PTR_W + 1;

  typedef enum logic [1:0] {
    REQ_LOAD_VALUE  = 2'd0,
    REQ_LOAD_VECTOR = 2'd1,
    REQ_TERM        = 2'd2,
    REQ_EMPTY_ROW   = 2'd3
  } req_type_t;

  typedef struct packed {
    req_type_t          req_type;
    logic [11:0]        column;
    logic [7:0]         value_slot;
    logic signed [31:0] data;
    logic               row_end;
  } in_t;

  typedef struct packed {
    logic [15:0]        row;
    logic signed [31:0] y_value;
  } out_t;

  // control that travels with an item down the pipe
  typedef struct packed {
    logic term;   // multiply-accumulate this item
    logic emit;   // this item closes a row
  } stage_t;

  function automatic logic signed [63:0] sat_add64(input logic signed [63:0] a,
                                                   input logic signed [63:0] b);
    logic signed [64:0] s;
    s = {a[63], a} + {b[63], b};
    if (s[64] != s[63]) begin
      sat_add64 = s[64] ? {1'b1, 63'd0} : {1'b0, {63{1'b1}}};
    end else begin
      sat_add64 = s[63:0];
    end
  endfunction

  // Q32.32 to Q16.16, round half up, then saturate
  function automatic logic signed [31:0] round_q16(input logic signed [63:0] acc);
    logic signed [64:0] t;
    logic signed [48:0] q;
    t = {acc[63], acc} + 65'sd32768;
    q = t[64:16];
    if (q > 49'sd2147483647) begin
      round_q16 = {1'b0, {31{1'b1}}};
    end else if (q < -49'sd2147483648) begin
      round_q16 = {1'b1, 31'd0};
    end else begin
      round_q16 = q[31:0];
    end
  endfunction

endpackage

// ----- hw/rtl/csrvi_mem.sv -----
// ----------------------------------------------------------------------------
// csrvi_mem
// Value table and dense vector memory. Loads write, terms read; read data
// is registered and lines up with the item's control in the first stage.
// ----------------------------------------------------------------------------
module csrvi_mem (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_fire,
  input  csrvi_pkg::in_t       in_data,
  output csrvi_pkg::stage_t    st1_r,
  output logic signed [31:0]   a_r,
  output logic signed [31:0]   x_r
);
  import csrvi_pkg::*;

  logic [31:0] value_table  [VALUE_SLOTS];
  logic [31:0] vector_mem   [VECTOR_DEPTH];

  logic [SLOT_W-1:0] slot_idx;
  logic [COL_W-1:0]  col_idx;
  stage_t            st1_nxt;

  assign slot_idx = SLOT_W'(in_data.value_slot);
  assign col_idx  = COL_W'(in_data.column);

  always_comb begin
    st1_nxt.term = 1'b0;
    st1_nxt.emit = 1'b0;
    if (in_fire) begin
      case (in_data.req_type)
        REQ_TERM: begin
          st1_nxt.term = 1'b1;
          st1_nxt.emit = in_data.row_end;
        end
        REQ_EMPTY_ROW: begin
          st1_nxt.emit = 1'b1;
        end
        default: begin
          st1_nxt.term = 1'b0;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire && in_data.req_type == REQ_LOAD_VALUE) begin
      value_table[slot_idx] <= in_data.data;
    end
    a_r <= value_table[slot_idx];
  end

  always_ff @(posedge clk) begin
    if (in_fire && in_data.req_type == REQ_LOAD_VECTOR) begin
      vector_mem[col_idx] <= in_data.data;
    end
    x_r <= vector_mem[col_idx];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st1_r <= '0;
    end else begin
      st1_r <= st1_nxt;
    end
  end

endmodule

// ----- hw/rtl/csrvi_mac.sv -----
// ----------------------------------------------------------------------------
// csrvi_mac
// Registered 32x32 product, saturating row accumulator, row counter and
// output rounding.
// ----------------------------------------------------------------------------
module csrvi_mac (
  input  logic                 clk,
  input  logic                 rst_n,
  input  csrvi_pkg::stage_t    st1,
  input  logic signed [31:0]   a,
  input  logic signed [31:0]   x,
  output logic [1:0]           pend_cnt,
  output logic                 res_push,
  output csrvi_pkg::out_t      res
);
  import csrvi_pkg::*;

  logic signed [63:0]        prod_r;
  stage_t                    st2_r;
  logic signed [63:0]        acc_r;
  logic signed [63:0]        acc_nxt;
  logic [ROW_COUNT_BITS-1:0] row_cnt_r;
  logic [ROW_COUNT_BITS-1:0] row_cnt_nxt;
  logic signed [63:0]        sum;
  logic signed [63:0]        sum3_r;
  logic [15:0]               row3_r;
  logic                      emit3_r;

  always_ff @(posedge clk) begin
    prod_r <= a * x;
  end

  always_comb begin
    sum         = st2_r.term ? sat_add64(acc_r, prod_r) : acc_r;
    acc_nxt     = acc_r;
    row_cnt_nxt = row_cnt_r;
    if (st2_r.emit) begin
      acc_nxt     = '0;
      row_cnt_nxt = row_cnt_r + 1'b1;
    end else if (st2_r.term) begin
      acc_nxt = sum;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st2_r     <= '0;
      acc_r     <= '0;
      row_cnt_r <= '0;
      emit3_r   <= 1'b0;
    end else begin
      st2_r     <= st1;
      acc_r     <= acc_nxt;
      row_cnt_r <= row_cnt_nxt;
      emit3_r   <= st2_r.emit;
    end
  end

  always_ff @(posedge clk) begin
    sum3_r <= sum;
    row3_r <= 16'(row_cnt_r);
  end

  assign pend_cnt    = {1'b0, st2_r.emit} + {1'b0, emit3_r};
  assign res_push    = emit3_r;
  assign res.row     = row3_r;
  assign res.y_value = round_q16(sum3_r);

endmodule

// ----- hw/rtl/csrvi_out_fifo.sv -----
// ----------------------------------------------------------------------------
// csrvi_out_fifo
// Small result queue between the pipeline and the output channel.
// ----------------------------------------------------------------------------
module csrvi_out_fifo (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 push,
  input  csrvi_pkg::out_t                      push_data,
  output logic [csrvi_pkg::FIFO_CNT_W-1:0]     count,
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output csrvi_pkg::out_t                      out_data
);
  import csrvi_pkg::*;

  out_t                  buf_r [OUT_FIFO_DEPTH];
  logic [FIFO_PTR_W-1:0] wr_ptr_r;
  logic [FIFO_PTR_W-1:0] rd_ptr_r;
  logic [FIFO_CNT_W-1:0] cnt_r;
  logic                  pop;

  assign out_valid = (cnt_r != '0);
  assign out_data  = buf_r[rd_ptr_r];
  assign pop       = out_valid && out_ready;
  assign count     = cnt_r;

  always_ff @(posedge clk) begin
    if (push) begin
      buf_r[wr_ptr_r] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
      case ({push, pop})
        2'b10:   cnt_r <= cnt_r + 1'b1;
        2'b01:   cnt_r <= cnt_r - 1'b1;
        default: cnt_r <= cnt_r;
      endcase
    end
  end

endmodule

// ----- hw/rtl/csr_value_indexed_spmv_unit.sv -----
// ----------------------------------------------------------------------------
// csr_value_indexed_spmv_unit
// Value-indexed CSR sparse matrix-vector multiply, one transaction a cycle.
// ----------------------------------------------------------------------------
// Takes one transaction per cycle while in_ready is high: loads, nonzero
// terms and empty rows stream back to back. A term's table and vector
// reads are registered when it is accepted, its product is registered
// next, and the sum then updates the saturating Q32.32 row accumulator,
// whose loop through acc_r alone lets terms of one row follow one another
// each cycle. A row result passes st1_r, st2_r and emit3_r into an
// eight-entry buffer and shows on out_valid once its count holds it;
// in_ready drops only when that buffer plus the rows still in the pipe
// would fill it, i.e. after the output side has stalled for several rows.
// Table and vector entries must be loaded before a term reads them.
module csr_value_indexed_spmv_unit (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  csrvi_pkg::in_t    in_data,
  output logic              out_valid,
  input  logic              out_ready,
  output csrvi_pkg::out_t   out_data
);
  import csrvi_pkg::*;

  logic                  in_fire;
  stage_t                st1;
  logic signed [31:0]    a_val;
  logic signed [31:0]    x_val;
  logic [1:0]            pend_cnt;
  logic                  res_push;
  out_t                  res;
  logic [FIFO_CNT_W-1:0] fifo_cnt;
  logic [FIFO_CNT_W:0]   rows_owed;

  // rows already queued plus rows that may still land in the queue
  assign rows_owed = {1'b0, fifo_cnt} + (FIFO_CNT_W + 1)'(pend_cnt)
                   + (FIFO_CNT_W + 1)'(st1.emit);
  assign in_ready  = (rows_owed < (FIFO_CNT_W + 1)'(OUT_FIFO_DEPTH));
  assign in_fire   = in_valid && in_ready;

  csrvi_mem u_mem (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_fire (in_fire),
    .in_data (in_data),
    .st1_r   (st1),
    .a_r     (a_val),
    .x_r     (x_val)
  );

  csrvi_mac u_mac (
    .clk      (clk),
    .rst_n    (rst_n),
    .st1      (st1),
    .a        (a_val),
    .x        (x_val),
    .pend_cnt (pend_cnt),
    .res_push (res_push),
    .res      (res)
  );

  csrvi_out_fifo u_out_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (res_push),
    .push_data (res),
    .count     (fifo_cnt),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

// ----- tb/sv/csr_value_indexed_spmv_checker.sv -----
// ----------------------------------------------------------------------------
// csr_value_indexed_spmv_checker
// Watches both channels of the spmv unit, keeps its own copy of the value
// table, vector memory, row accumulator and row counter, and compares every
// row result with the predicted one.
// ----------------------------------------------------------------------------
module csr_value_indexed_spmv_checker (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  input  logic            in_ready,
  input  csrvi_pkg::in_t  in_data,
  input  logic            out_valid,
  input  logic            out_ready,
  input  csrvi_pkg::out_t out_data,
  output int              mismatches,
  output int              pending,
  output int              rows_checked
);
  import csrvi_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic signed [64:0] SUM_MAX = 65'sh0_7FFF_FFFF_FFFF_FFFF;
  localparam logic signed [64:0] SUM_MIN = -65'sh0_8000_0000_0000_0000;
  localparam logic signed [64:0] Q16_MAX = 65'sd2147483647;
  localparam logic signed [64:0] Q16_MIN = -65'sd2147483648;
  localparam int REPORT_CAP = 100;

  logic signed [31:0]         value_table [VALUE_SLOTS];
  logic signed [31:0]         vector_mem [VECTOR_DEPTH];
  logic signed [63:0]         row_sum;
  logic [ROW_COUNT_BITS-1:0]  row_index;
  out_t                       expected_rows [$];

  initial begin
    mismatches   = 0;
    pending      = 0;
    rows_checked = 0;
  end

  function automatic logic signed [63:0] add_clamped(input logic signed [63:0] a,
                                                     input logic signed [63:0] b);
    logic signed [64:0] s;
    s = {a[63], a} + {b[63], b};
    if (s > SUM_MAX) return SUM_MAX[63:0];
    if (s < SUM_MIN) return SUM_MIN[63:0];
    return s[63:0];
  endfunction

  // q32.32 to q16.16: add half an lsb, floor, clamp to 32 bits
  function automatic logic signed [31:0] to_q16(input logic signed [63:0] acc);
    logic signed [64:0] t;
    logic signed [64:0] q;
    t = {acc[63], acc} + 65'sd32768;
    q = t >>> 16;
    if (q > Q16_MAX) return 32'h7FFF_FFFF;
    if (q < Q16_MIN) return 32'h8000_0000;
    return q[31:0];
  endfunction

  task automatic close_row();
    out_t row_result;
    row_result.row     = row_index;
    row_result.y_value = to_q16(row_sum);
    expected_rows.push_back(row_result);
    row_sum   = '0;
    row_index = row_index + 1'b1;
  endtask

  always @(posedge clk) begin : watch
    out_t               want;
    logic signed [63:0] mat_val;
    logic signed [63:0] vec_val;
    if (!rst_n) begin
      row_sum   = '0;
      row_index = '0;
      expected_rows.delete();
    end else begin
      if (out_valid && out_ready) begin
        if (expected_rows.size() == 0) begin
          mismatches <= mismatches + 1;
          if (mismatches < REPORT_CAP)
            $error("unexpected result transaction: row %0d y_value %0d",
                   out_data.row, out_data.y_value);
        end else begin
          want = expected_rows.pop_front();
          rows_checked <= rows_checked + 1;
          if (out_data.row !== want.row || out_data.y_value !== want.y_value) begin
            mismatches <= mismatches + 1;
            if (mismatches < REPORT_CAP) begin
              if (out_data.row !== want.row)
                $error("row: expected %0d, got %0d", want.row, out_data.row);
              if (out_data.y_value !== want.y_value)
                $error("y_value: expected %0d, got %0d", want.y_value, out_data.y_value);
            end
          end
        end
      end
      if (in_valid && in_ready) begin
        case (in_data.req_type)
          REQ_LOAD_VALUE:  value_table[in_data.value_slot] = in_data.data;
          REQ_LOAD_VECTOR: vector_mem[in_data.column] = in_data.data;
          REQ_TERM: begin
            mat_val = value_table[in_data.value_slot];
            vec_val = vector_mem[in_data.column];
            // product of two q16.16 values fits a q32.32 word exactly
            row_sum = add_clamped(row_sum, mat_val * vec_val);
            if (in_data.row_end) close_row();
          end
          default: close_row();
        endcase
      end
    end
    pending <= expected_rows.size();
  end

endmodule

// ----- tb/sv/csr_value_indexed_spmv_unit_tb.sv -----
// ----------------------------------------------------------------------------
// csr_value_indexed_spmv_unit_tb
// Streams loads, nonzero terms and empty rows into the spmv unit under
// several handshake pressure phases; the checker predicts and compares
// every row result.
// ----------------------------------------------------------------------------
module csr_value_indexed_spmv_unit_tb;
  import csrvi_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int RANDOM_PER_PHASE = 400;
  localparam int NUM_PHASES       = 4;
  localparam int DRAIN_CYCLES     = 20;

  logic clk       = 1'b0;
  logic rst_n     = 1'b0;
  logic in_valid  = 1'b0;
  in_t  in_data   = '0;
  logic out_ready = 1'b0;
  logic in_ready;
  logic out_valid;
  out_t out_data;

  int mismatches;
  int pending;
  int rows_checked;

  int idle_pct    = 0;
  int stall_pct   = 0;
  int sent        = 0;
  int rows_closed = 0;

  bit          slot_loaded [VALUE_SLOTS];
  bit          col_loaded [VECTOR_DEPTH];
  logic [7:0]  loaded_slots [$];
  logic [11:0] loaded_cols [$];

  int phase_idle  [NUM_PHASES] = '{0, 73, 0, 26};
  int phase_stall [NUM_PHASES] = '{0, 0, 73, 26};

  csr_value_indexed_spmv_unit uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  csr_value_indexed_spmv_checker row_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_data      (in_data),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_data     (out_data),
    .mismatches   (mismatches),
    .pending      (pending),
    .rows_checked (rows_checked)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    out_ready <= ($urandom_range(99) >= stall_pct);
  end

  initial begin
    #20ms;
    $display("** csr_value_indexed_spmv_unit: FAILED **");
    $finish;
  end

  function automatic in_t make_req(input req_type_t kind, input logic [11:0] col,
                                   input logic [7:0] slot, input logic [31:0] data,
                                   input logic last);
    in_t req;
    req.req_type   = kind;
    req.column     = col;
    req.value_slot = slot;
    req.data       = data;
    req.row_end    = last;
    return req;
  endfunction

  function automatic logic [31:0] pick_data();
    int v;
    case ($urandom_range(3))
      0: return $urandom();
      1: begin
        v = int'($urandom_range(262143)) - 131072;
        return v;
      end
      2: begin
        case ($urandom_range(4))
          0:       return 32'h7FFF_FFFF;
          1:       return 32'h8000_0000;
          2:       return 32'h0000_0000;
          3:       return 32'h0001_0000;
          default: return 32'hFFFF_FFFF;
        endcase
      end
      default: return {16'h0000, 16'($urandom())};
    endcase
  endfunction

  // terms only read entries that were loaded earlier
  function automatic in_t pick_term(input logic last);
    return make_req(REQ_TERM, loaded_cols[$urandom_range(loaded_cols.size() - 1)],
                    loaded_slots[$urandom_range(loaded_slots.size() - 1)],
                    $urandom(), last);
  endfunction

  task automatic drive_request(input in_t req);
    int gap;
    gap = 0;
    while ($urandom_range(99) < idle_pct && gap < 60) gap++;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= req;
    do @(posedge clk); while (!in_ready);
    sent++;
    case (req.req_type)
      REQ_LOAD_VALUE: begin
        if (!slot_loaded[req.value_slot]) begin
          slot_loaded[req.value_slot] = 1'b1;
          loaded_slots.push_back(req.value_slot);
        end
      end
      REQ_LOAD_VECTOR: begin
        if (!col_loaded[req.column]) begin
          col_loaded[req.column] = 1'b1;
          loaded_cols.push_back(req.column);
        end
      end
      REQ_TERM: if (req.row_end) rows_closed++;
      default: rows_closed++;
    endcase
  endtask

  task automatic random_request();
    int pick;
    pick = $urandom_range(99);
    if (pick < 12)
      drive_request(make_req(REQ_LOAD_VALUE, 12'($urandom()), 8'($urandom()),
                             pick_data(), 1'($urandom())));
    else if (pick < 24)
      drive_request(make_req(REQ_LOAD_VECTOR, 12'($urandom()), 8'($urandom()),
                             pick_data(), 1'($urandom())));
    else if (pick < 90)
      drive_request(pick_term($urandom_range(3) == 0));
    else
      drive_request(make_req(REQ_EMPTY_ROW, 12'($urandom()), 8'($urandom()),
                             $urandom(), 1'($urandom())));
  endtask

  initial begin
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    // table and vector extremes, plus a few exact fractions
    drive_request(make_req(REQ_LOAD_VALUE,  12'hFFF, 8'd0,   32'h7FFF_FFFF, 1'b1));
    drive_request(make_req(REQ_LOAD_VALUE,  12'h000, 8'd255, 32'h8000_0000, 1'b0));
    drive_request(make_req(REQ_LOAD_VALUE,  12'h5A5, 8'd1,   32'h0001_0000, 1'b1));
    drive_request(make_req(REQ_LOAD_VALUE,  12'hA5A, 8'd2,   32'h0000_8000, 1'b0));
    drive_request(make_req(REQ_LOAD_VALUE,  12'h123, 8'd3,   32'hFFFF_8000, 1'b1));
    drive_request(make_req(REQ_LOAD_VECTOR, 12'h000, 8'hFF,  32'h8000_0000, 1'b1));
    drive_request(make_req(REQ_LOAD_VECTOR, 12'hFFF, 8'h00,  32'h7FFF_FFFF, 1'b0));
    drive_request(make_req(REQ_LOAD_VECTOR, 12'h001, 8'hAA,  32'h0001_0000, 1'b1));
    drive_request(make_req(REQ_LOAD_VECTOR, 12'h002, 8'h55,  32'h0000_0001, 1'b0));
    // single product too big for q16.16
    drive_request(make_req(REQ_TERM, 12'h000, 8'd255, 32'hFFFF_FFFF, 1'b1));
    // accumulator clamps high, then low
    drive_request(make_req(REQ_TERM, 12'h000, 8'd255, 32'h0, 1'b0));
    drive_request(make_req(REQ_TERM, 12'h000, 8'd255, 32'h0, 1'b0));
    drive_request(make_req(REQ_TERM, 12'h000, 8'd255, 32'h0, 1'b1));
    drive_request(make_req(REQ_TERM, 12'h000, 8'd0,   32'h0, 1'b0));
    drive_request(make_req(REQ_TERM, 12'h000, 8'd0,   32'h0, 1'b0));
    drive_request(make_req(REQ_TERM, 12'h000, 8'd0,   32'h0, 1'b1));
    // exact half lsb, positive and negative
    drive_request(make_req(REQ_TERM, 12'h002, 8'd2, 32'h0, 1'b1));
    drive_request(make_req(REQ_TERM, 12'h002, 8'd3, 32'h0, 1'b1));
    drive_request(make_req(REQ_EMPTY_ROW, 12'h000, 8'h00, 32'h0, 1'b0));
    // empty row while a term is still pending
    drive_request(make_req(REQ_TERM, 12'h001, 8'd1, 32'h0, 1'b0));
    drive_request(make_req(REQ_EMPTY_ROW, 12'hFFF, 8'hFF, 32'hFFFF_FFFF, 1'b1));
    drive_request(make_req(REQ_TERM, 12'hFFF, 8'd0,   32'h0, 1'b1));
    drive_request(make_req(REQ_TERM, 12'hFFF, 8'd255, 32'h0, 1'b1));

    for (int p = 0; p < NUM_PHASES; p++) begin
      idle_pct  = phase_idle[p];
      stall_pct = phase_stall[p];
      repeat (RANDOM_PER_PHASE) random_request();
    end

    idle_pct  = 0;
    stall_pct = 0;
    in_valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("sent %0d transactions closing %0d rows over four handshake phases",
             sent, rows_closed);
    $display("checked %0d row results, %0d mismatches", rows_checked, mismatches);
    if (mismatches == 0 && pending == 0) begin
      $display("** csr_value_indexed_spmv_unit: PASSED **");
    end else begin
      $display("** csr_value_indexed_spmv_unit: FAILED **");
    end
    $finish;
  end

endmodule

// ----- files.f -----
hw/rtl/csrvi_pkg.sv
hw/rtl/csrvi_mem.sv
hw/rtl/csrvi_mac.sv
hw/rtl/csrvi_out_fifo.sv
hw/rtl/csr_value_indexed_spmv_unit.sv
tb/sv/csr_value_indexed_spmv_checker.sv
tb/sv/csr_value_indexed_spmv_unit_tb.sv
